[rtl/core/opvs_pkg.sv]
// ----------------------------------------------------------------------------
// opvs_pkg
// Shared widths, divisor classes and decode structures for the OBD-II
// service 01 PID value scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package opvs_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned VALUE_W       = 49;   // scaled value, two's complement
    localparam int unsigned RAW_W         = 32;
    localparam int unsigned NUM_W         = 34;   // signed numerator, shift path
    localparam int unsigned SH_W          = 4;    // power-of-two divisor shift
    localparam int unsigned N_W           = 23;   // unsigned numerator, divide path
    localparam int unsigned Q_W           = 15;   // integer quotient, divide path
    localparam int unsigned R_W           = 10;   // remainder and divisor

    // divisors that are not a power of two
    typedef enum logic [2:0] {
        DV_10,
        DV_20,
        DV_100,
        DV_200,
        DV_255,
        DV_1000
    } t_dcls;

    // odd factor of the divisor
    typedef enum logic [1:0] {
        MC_5,
        MC_25,
        MC_125,
        MC_255
    } t_mcode;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic [SH_W-1:0]         sh;
        logic                    use_div;
        t_dcls                   dcls;
        logic [N_W-1:0]          n;
        logic                    sub40;
        logic [RAW_W-1:0]        raw;
        logic                    is_raw;
    } t_dec;

    typedef struct packed {
        logic [VALUE_W-1:0] direct;
        logic               use_div;
        logic               sub40;
        t_dcls              dcls;
        logic [RAW_W-1:0]   raw;
        logic               is_raw;
    } t_carry;

    // power-of-two part of the divisor
    function automatic logic [1:0] dv_k(input t_dcls c);
        logic [1:0] k;
        case (c)
            DV_10:   k = 2'd1;
            DV_20:   k = 2'd2;
            DV_100:  k = 2'd2;
            DV_200:  k = 2'd3;
            DV_255:  k = 2'd0;
            DV_1000: k = 2'd3;
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    function automatic t_mcode dv_m(input t_dcls c);
        t_mcode m;
        case (c)
            DV_10:   m = MC_5;
            DV_20:   m = MC_5;
            DV_100:  m = MC_25;
            DV_200:  m = MC_25;
            DV_255:  m = MC_255;
            DV_1000: m = MC_125;
            default: m = MC_5;
        endcase
        return m;
    endfunction

    function automatic logic [R_W-1:0] dv_den(input t_dcls c);
        logic [R_W-1:0] d;
        case (c)
            DV_10:   d = R_W'(10);
            DV_20:   d = R_W'(20);
            DV_100:  d = R_W'(100);
            DV_200:  d = R_W'(200);
            DV_255:  d = R_W'(255);
            DV_1000: d = R_W'(1000);
            default: d = R_W'(10);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/opvs_decode.sv]
// ----------------------------------------------------------------------------
// opvs_decode
// Maps a PID and its data bytes onto a numerator, a divisor class, the raw
// word and the raw-field flag.
// ----------------------------------------------------------------------------
`default_nettype none

module opvs_decode (
    input  wire logic [7:0]      i_pid_number,
    input  wire logic [7:0]      i_byte_a,
    input  wire logic [7:0]      i_byte_b,
    input  wire logic [7:0]      i_byte_c,
    input  wire logic [7:0]      i_byte_d,
    output opvs_pkg::t_dec       o_dec
);
    import opvs_pkg::*;

    localparam logic [7:0] PID_PIDS_A       = 8'h00;
    localparam logic [7:0] PID_MON_STATUS   = 8'h01;
    localparam logic [7:0] PID_FREEZE_DTC   = 8'h02;
    localparam logic [7:0] PID_FUEL_SYS     = 8'h03;
    localparam logic [7:0] PID_ENG_LOAD     = 8'h04;
    localparam logic [7:0] PID_COOLANT_T    = 8'h05;
    localparam logic [7:0] PID_TRIM_FIRST   = 8'h06;
    localparam logic [7:0] PID_TRIM_LAST    = 8'h09;
    localparam logic [7:0] PID_FUEL_PRES    = 8'h0A;
    localparam logic [7:0] PID_MAP          = 8'h0B;
    localparam logic [7:0] PID_RPM          = 8'h0C;
    localparam logic [7:0] PID_SPEED        = 8'h0D;
    localparam logic [7:0] PID_TIMING_ADV   = 8'h0E;
    localparam logic [7:0] PID_IAT          = 8'h0F;
    localparam logic [7:0] PID_MAF          = 8'h10;
    localparam logic [7:0] PID_THROTTLE     = 8'h11;
    localparam logic [7:0] PID_SEC_AIR      = 8'h12;
    localparam logic [7:0] PID_O2_PRESENT   = 8'h13;
    localparam logic [7:0] PID_O2V_FIRST    = 8'h14;
    localparam logic [7:0] PID_O2V_LAST     = 8'h1B;
    localparam logic [7:0] PID_OBD_STD      = 8'h1C;
    localparam logic [7:0] PID_O2_PRES4     = 8'h1D;
    localparam logic [7:0] PID_AUX_INPUT    = 8'h1E;
    localparam logic [7:0] PID_RUN_TIME     = 8'h1F;
    localparam logic [7:0] PID_PIDS_B       = 8'h20;
    localparam logic [7:0] PID_DIST_MIL     = 8'h21;
    localparam logic [7:0] PID_FRP_REL      = 8'h22;
    localparam logic [7:0] PID_FRP_GAUGE    = 8'h23;
    localparam logic [7:0] PID_O2WV_FIRST   = 8'h24;
    localparam logic [7:0] PID_O2WV_LAST    = 8'h2B;
    localparam logic [7:0] PID_EGR_CMD      = 8'h2C;
    localparam logic [7:0] PID_EGR_ERR      = 8'h2D;
    localparam logic [7:0] PID_EVAP_CMD     = 8'h2E;
    localparam logic [7:0] PID_FUEL_LEVEL   = 8'h2F;
    localparam logic [7:0] PID_WARMUPS      = 8'h30;
    localparam logic [7:0] PID_DIST_CLR     = 8'h31;
    localparam logic [7:0] PID_EVAP_VP      = 8'h32;
    localparam logic [7:0] PID_BARO         = 8'h33;
    localparam logic [7:0] PID_O2WI_FIRST   = 8'h34;
    localparam logic [7:0] PID_O2WI_LAST    = 8'h3B;
    localparam logic [7:0] PID_CAT_FIRST    = 8'h3C;
    localparam logic [7:0] PID_CAT_LAST     = 8'h3F;
    localparam logic [7:0] PID_PIDS_C       = 8'h40;
    localparam logic [7:0] PID_MON_DRIVE    = 8'h41;
    localparam logic [7:0] PID_CTRL_VOLT    = 8'h42;
    localparam logic [7:0] PID_ABS_LOAD     = 8'h43;
    localparam logic [7:0] PID_CMD_LAMBDA   = 8'h44;
    localparam logic [7:0] PID_REL_THROT    = 8'h45;
    localparam logic [7:0] PID_AMB_T        = 8'h46;
    localparam logic [7:0] PID_TPS_B        = 8'h47;
    localparam logic [7:0] PID_TPS_C        = 8'h48;
    localparam logic [7:0] PID_APP_D        = 8'h49;
    localparam logic [7:0] PID_APP_E        = 8'h4A;
    localparam logic [7:0] PID_APP_F        = 8'h4B;
    localparam logic [7:0] PID_CMD_THROT    = 8'h4C;
    localparam logic [7:0] PID_TIME_MIL     = 8'h4D;
    localparam logic [7:0] PID_TIME_CLR     = 8'h4E;
    localparam logic [7:0] PID_FUEL_TYPE    = 8'h51;
    localparam logic [7:0] PID_ETHANOL      = 8'h52;
    localparam logic [7:0] PID_EVAP_ABS     = 8'h53;
    localparam logic [7:0] PID_EVAP_VP2     = 8'h54;
    localparam logic [7:0] PID_FRP_ABS      = 8'h59;
    localparam logic [7:0] PID_REL_APP      = 8'h5A;
    localparam logic [7:0] PID_HYB_BATT     = 8'h5B;
    localparam logic [7:0] PID_OIL_T        = 8'h5C;
    localparam logic [7:0] PID_INJ_TIMING   = 8'h5D;
    localparam logic [7:0] PID_FUEL_RATE    = 8'h5E;
    localparam logic [7:0] PID_EMISSION_REQ = 8'h5F;

    logic [15:0]      w_ab;
    logic [RAW_W-1:0] w_word;

    assign w_ab   = {i_byte_a, i_byte_b};
    assign w_word = {i_byte_a, i_byte_b, i_byte_c, i_byte_d};

    always_comb begin
        o_dec         = '0;
        o_dec.num     = NUM_W'(w_word);
        o_dec.dcls    = DV_10;
        o_dec.raw     = w_word;
        case (i_pid_number)
            PID_PIDS_A, PID_MON_STATUS, PID_FREEZE_DTC, PID_PIDS_B, PID_PIDS_C,
            PID_MON_DRIVE: begin
                o_dec.is_raw = 1'b1;
            end
            PID_FUEL_SYS: begin
                o_dec.num    = NUM_W'(w_ab);
                o_dec.raw    = RAW_W'(w_ab);
                o_dec.is_raw = 1'b1;
            end
            PID_RUN_TIME, PID_DIST_MIL, PID_DIST_CLR, PID_TIME_MIL, PID_TIME_CLR: begin
                o_dec.num = NUM_W'(w_ab);
            end
            PID_ENG_LOAD, PID_THROTTLE, PID_EGR_CMD, PID_EVAP_CMD, PID_FUEL_LEVEL,
            PID_REL_THROT, PID_TPS_B, PID_TPS_C, PID_APP_D, PID_APP_E, PID_APP_F,
            PID_CMD_THROT, PID_ETHANOL, PID_REL_APP, PID_HYB_BATT: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_255;
                o_dec.n       = N_W'(i_byte_a) * N_W'(100);
            end
            PID_SEC_AIR, PID_O2_PRESENT, PID_OBD_STD, PID_O2_PRES4, PID_AUX_INPUT,
            PID_FUEL_TYPE, PID_EMISSION_REQ: begin
                o_dec.num    = NUM_W'(i_byte_a);
                o_dec.raw    = RAW_W'(i_byte_a);
                o_dec.is_raw = 1'b1;
            end
            PID_MAP, PID_SPEED, PID_WARMUPS, PID_BARO: begin
                o_dec.num = NUM_W'(i_byte_a);
            end
            PID_COOLANT_T, PID_IAT, PID_AMB_T, PID_OIL_T: begin
                o_dec.num = NUM_W'(i_byte_a) - NUM_W'(40);
            end
            PID_EGR_ERR: begin
                o_dec.num = NUM_W'(i_byte_a) * NUM_W'(100) - NUM_W'(12800);
                o_dec.sh  = SH_W'(7);
            end
            PID_FUEL_PRES: begin
                o_dec.num = NUM_W'(i_byte_a) * NUM_W'(3);
            end
            PID_RPM: begin
                o_dec.num = NUM_W'(w_ab);
                o_dec.sh  = SH_W'(2);
            end
            PID_TIMING_ADV: begin
                o_dec.num = NUM_W'(i_byte_a) - NUM_W'(128);
                o_dec.sh  = SH_W'(1);
            end
            PID_MAF: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_100;
                o_dec.n       = N_W'(w_ab);
            end
            PID_FRP_REL: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_1000;
                o_dec.n       = N_W'(w_ab) * N_W'(79);
            end
            PID_FRP_GAUGE, PID_FRP_ABS: begin
                o_dec.num = NUM_W'(w_ab) * NUM_W'(10);
            end
            PID_CMD_LAMBDA: begin
                o_dec.num = NUM_W'(w_ab);
                o_dec.sh  = SH_W'(15);
            end
            PID_EVAP_VP: begin
                // two's complement pressure
                o_dec.num = NUM_W'($signed(w_ab));
                o_dec.sh  = SH_W'(2);
            end
            PID_CTRL_VOLT: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_1000;
                o_dec.n       = N_W'(w_ab);
            end
            PID_ABS_LOAD: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_255;
                o_dec.n       = N_W'(w_ab) * N_W'(100);
            end
            PID_EVAP_ABS: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_200;
                o_dec.n       = N_W'(w_ab);
            end
            PID_EVAP_VP2: begin
                o_dec.num = NUM_W'(w_ab) - NUM_W'(32767);
            end
            PID_INJ_TIMING: begin
                o_dec.num = NUM_W'(w_ab) - NUM_W'(26880);
                o_dec.sh  = SH_W'(7);
            end
            PID_FUEL_RATE: begin
                o_dec.use_div = 1'b1;
                o_dec.dcls    = DV_20;
                o_dec.n       = N_W'(w_ab);
            end
            default: begin
                if (i_pid_number >= PID_TRIM_FIRST && i_pid_number <= PID_TRIM_LAST) begin
                    o_dec.num = NUM_W'(i_byte_a) * NUM_W'(100) - NUM_W'(12800);
                    o_dec.sh  = SH_W'(7);
                end else if (i_pid_number >= PID_O2V_FIRST && i_pid_number <= PID_O2V_LAST) begin
                    o_dec.num = NUM_W'(i_byte_b) * NUM_W'(100) - NUM_W'(12800);
                    o_dec.sh  = SH_W'(7);
                end else if ((i_pid_number >= PID_O2WV_FIRST && i_pid_number <= PID_O2WV_LAST) ||
                             (i_pid_number >= PID_O2WI_FIRST && i_pid_number <= PID_O2WI_LAST)) begin
                    o_dec.num = NUM_W'(w_ab);
                    o_dec.sh  = SH_W'(15);
                end else if (i_pid_number >= PID_CAT_FIRST && i_pid_number <= PID_CAT_LAST) begin
                    // ab/10 - 40, offset applied after the divide
                    o_dec.use_div = 1'b1;
                    o_dec.dcls    = DV_10;
                    o_dec.n       = N_W'(w_ab);
                    o_dec.sub40   = 1'b1;
                end else begin
                    o_dec.is_raw = (i_pid_number > PID_EMISSION_REQ);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/opvs_mdiv.sv]
// ----------------------------------------------------------------------------
// opvs_mdiv
// Exact floor division of an unsigned word by 5, 25, 125 or 255: multiply by
// a rounded-up reciprocal into a register, then take the high bits.
// ----------------------------------------------------------------------------
`default_nettype none

module opvs_mdiv #(
    parameter int unsigned XW = opvs_pkg::N_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_x,
    input  wire opvs_pkg::t_mcode  i_m,
    output logic [XW-1:0]          o_q
);
    import opvs_pkg::*;

    localparam int unsigned RW   = XW + 1;
    localparam int unsigned PW   = 2 * XW + 1;
    localparam int unsigned S5   = XW + 3;
    localparam int unsigned S25  = XW + 5;
    localparam int unsigned S125 = XW + 7;
    localparam int unsigned S255 = XW + 8;
    // shift of XW plus ceil(log2 m) keeps the quotient exact over the whole input
    localparam logic [RW-1:0] R5   = RW'(((64'd1 << S5) + 64'd4) / 64'd5);
    localparam logic [RW-1:0] R25  = RW'(((64'd1 << S25) + 64'd24) / 64'd25);
    localparam logic [RW-1:0] R125 = RW'(((64'd1 << S125) + 64'd124) / 64'd125);
    localparam logic [RW-1:0] R255 = RW'(((64'd1 << S255) + 64'd254) / 64'd255);

    logic [RW-1:0] w_rcp;
    logic [PW-1:0] r_prod;
    t_mcode        r_m;

    always_comb begin
        case (i_m)
            MC_5:    w_rcp = R5;
            MC_25:   w_rcp = R25;
            MC_125:  w_rcp = R125;
            MC_255:  w_rcp = R255;
            default: w_rcp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_x) * PW'(w_rcp);
            r_m    <= i_m;
        end
    end

    always_comb begin
        case (r_m)
            MC_5:    o_q = XW'(r_prod >> S5);
            MC_25:   o_q = XW'(r_prod >> S25);
            MC_125:  o_q = XW'(r_prod >> S125);
            MC_255:  o_q = XW'(r_prod >> S255);
            default: o_q = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/obd2_pid_value_scaler_unit.sv]
// ----------------------------------------------------------------------------
// obd2_pid_value_scaler_unit
// OBD-II service 01 PID decoder: engineering value in signed fixed point,
// raw word and raw-field flag for one response word per cycle, unless the output stalls.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready  | i_pid_number, i_byte_a .. i_byte_d
//  out     | o_out_valid / i_out_ready| o_value_q16, o_raw_word, o_is_raw
//
//  One word per cycle unless the output stalls; o_out_valid is registered.
//  The depth comes from the two reciprocal multipliers (integer quotient,
//  then rounded fraction), each followed by a register.
//  Reset clears only the stage valid flags.
//  A stall at the output holds the pipeline; empty stages still fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module obd2_pid_value_scaler_unit #(
    parameter int unsigned FRAC_BITS = opvs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_pid_number,
    input  wire logic [7:0]                    i_byte_a,
    input  wire logic [7:0]                    i_byte_b,
    input  wire logic [7:0]                    i_byte_c,
    input  wire logic [7:0]                    i_byte_d,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [opvs_pkg::VALUE_W-1:0] o_value_q16,
    output logic [opvs_pkg::RAW_W-1:0]         o_raw_word,
    output logic                               o_is_raw
);
    import opvs_pkg::*;

    localparam int unsigned DW = NUM_W + FRAC_BITS;   // shift path before rounding
    localparam int unsigned ZW = FRAC_BITS + 8;       // fraction dividend
    localparam int unsigned YW = FRAC_BITS + 12;
    localparam logic [VALUE_W-1:0] CAT_OFFSET = VALUE_W'(40);

    // enables
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    // stage 1: input register
    logic       r_s1_vld;
    logic [7:0] r_s1_pid, r_s1_a, r_s1_b, r_s1_c, r_s1_d;

    t_dec                w_dec;
    logic signed [DW-1:0] w_scaled;
    logic [DW-1:0]       w_rnd;
    t_carry              w_c1;
    logic [N_W-1:0]      w_q1;

    // stage 2: integer quotient product
    logic           r_s2_vld;
    t_carry         r_s2_c;
    logic [N_W-1:0] r_s2_n;
    logic [Q_W-1:0] w_q2;
    logic [N_W-1:0] w_qd;
    logic [R_W-1:0] w_r2;

    // stage 3: quotient and remainder
    logic           r_s3_vld;
    t_carry         r_s3_c;
    logic [Q_W-1:0] r_s3_q;
    logic [R_W-1:0] r_s3_r;
    logic [YW-1:0]  w_y;
    logic [ZW-1:0]  w_z;

    // stage 4: fraction product
    logic           r_s4_vld;
    t_carry         r_s4_c;
    logic [Q_W-1:0] r_s4_q;
    logic [ZW-1:0]  w_frac;
    logic [VALUE_W-1:0] n_value;

    // stage 5: result register
    logic               r_o_vld;
    logic [VALUE_W-1:0] r_o_value;
    logic [RAW_W-1:0]   r_o_raw;
    logic               r_o_is_raw;

    assign w_en5      = !r_o_vld  || i_out_ready;
    assign w_en4      = !r_s4_vld || w_en5;
    assign w_en3      = !r_s3_vld || w_en4;
    assign w_en2      = !r_s2_vld || w_en3;
    assign w_en1      = !r_s1_vld || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_en1) r_s1_vld <= i_in_valid;
            if (w_en2) r_s2_vld <= r_s1_vld;
            if (w_en3) r_s3_vld <= r_s2_vld;
            if (w_en4) r_s4_vld <= r_s3_vld;
            if (w_en5) r_o_vld  <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_pid <= i_pid_number;
            r_s1_a   <= i_byte_a;
            r_s1_b   <= i_byte_b;
            r_s1_c   <= i_byte_c;
            r_s1_d   <= i_byte_d;
        end
    end

    opvs_decode u_decode (
        .i_pid_number (r_s1_pid),
        .i_byte_a     (r_s1_a),
        .i_byte_b     (r_s1_b),
        .i_byte_c     (r_s1_c),
        .i_byte_d     (r_s1_d),
        .o_dec        (w_dec)
    );

    // power-of-two divisors: round half up, then arithmetic shift
    assign w_rnd    = (w_dec.sh == '0) ? '0 : (DW'(1) << (w_dec.sh - 1'b1));
    assign w_scaled = (DW'(w_dec.num) <<< FRAC_BITS) + w_rnd;

    always_comb begin
        w_c1         = '0;
        w_c1.direct  = VALUE_W'(w_scaled >>> w_dec.sh);
        w_c1.use_div = w_dec.use_div;
        w_c1.sub40   = w_dec.sub40;
        w_c1.dcls    = w_dec.dcls;
        w_c1.raw     = w_dec.raw;
        w_c1.is_raw  = w_dec.is_raw;
    end

    opvs_mdiv #(
        .XW (N_W)
    ) u_mdiv_int (
        .i_clk (i_clk),
        .i_en  (w_en2),
        .i_x   (N_W'(w_dec.n >> dv_k(w_dec.dcls))),
        .i_m   (dv_m(w_dec.dcls)),
        .o_q   (w_q1)
    );

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_c <= w_c1;
            r_s2_n <= w_dec.n;
        end
    end

    assign w_q2 = Q_W'(w_q1);
    assign w_qd = N_W'(w_q2) * N_W'(dv_den(r_s2_c.dcls));
    assign w_r2 = R_W'(r_s2_n - w_qd);

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_c <= r_s2_c;
            r_s3_q <= w_q2;
            r_s3_r <= w_r2;
        end
    end

    // rounded fraction: floor((2*r*2^F + den) / (2*den)), power of two taken out first
    assign w_y = (YW'(r_s3_r) << (FRAC_BITS + 1)) + YW'(dv_den(r_s3_c.dcls));
    assign w_z = ZW'(w_y >> (3'(dv_k(r_s3_c.dcls)) + 3'd1));

    opvs_mdiv #(
        .XW (ZW)
    ) u_mdiv_frac (
        .i_clk (i_clk),
        .i_en  (w_en4),
        .i_x   (w_z),
        .i_m   (dv_m(r_s3_c.dcls)),
        .o_q   (w_frac)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4_c <= r_s3_c;
            r_s4_q <= r_s3_q;
        end
    end

    always_comb begin
        if (r_s4_c.use_div) begin
            n_value = (VALUE_W'(r_s4_q) << FRAC_BITS) + VALUE_W'(w_frac)
                    - (r_s4_c.sub40 ? (CAT_OFFSET << FRAC_BITS) : '0);
        end else begin
            n_value = r_s4_c.direct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_o_value  <= n_value;
            r_o_raw    <= r_s4_c.raw;
            r_o_is_raw <= r_s4_c.is_raw;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_value_q16 = $signed(r_o_value);
    assign o_raw_word  = r_o_raw;
    assign o_is_raw    = r_o_is_raw;

endmodule

`default_nettype wire
